// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the sorted time list sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sorted time list assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("sorted time list forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/core/stlom_pkg.sv =====
// Package with sizes, codes and types of the sorted time list.
`timescale 1ns / 1ps
package stlom_pkg;

  localparam int LIST_SIZE = 16;
  localparam int IDX_W     = $clog2(LIST_SIZE);
  localparam int CNT_W     = IDX_W;
  localparam int TIME_W    = 48;
  localparam int ORD_W     = 4;
  localparam int FILL_W    = 4;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_DRAINED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_RESULT,
    S_DRAIN_RD,
    S_DRAIN_OUT
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [ORD_W-1:0]  ord;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    status_e           status;
    logic [TIME_W-1:0] tstamp;
    logic [ORD_W-1:0]  ord;
    logic [FILL_W-1:0] fill;
    logic              last;
  } res_t;

  function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] c);
    logic [FILL_W+CNT_W-1:0] ext;
    ext = {{FILL_W{1'b0}}, c};
    return ext[FILL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/stlom_mem.sv =====
// Entry storage with one write port and one registered read port.
`timescale 1ns / 1ps
module stlom_mem (
  input  logic                           clk_i,
  input  stlom_pkg::mem_wr_t             wr_i,
  input  logic [stlom_pkg::IDX_W-1:0]    rd_addr_i,
  output stlom_pkg::entry_t              rd_data_o
);
  import stlom_pkg::*;

  entry_t mem_q [LIST_SIZE];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/stlom_seq.sv =====
// Sequencer that searches, shifts, inserts, merges and drains the list.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stlom_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [stlom_pkg::TIME_W-1:0]  event_time_i,
  input  logic [stlom_pkg::ORD_W-1:0]   event_order_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output stlom_pkg::res_t               res_o,
  output stlom_pkg::mem_wr_t            mem_wr_o,
  output logic [stlom_pkg::IDX_W-1:0]   mem_rd_addr_o,
  input  stlom_pkg::entry_t             mem_rd_data_i
);
  import stlom_pkg::*;

  state_e            state_q, state_d;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  ins_q, ins_d;
  logic [TIME_W-1:0] t_q, t_d;
  logic [ORD_W-1:0]  ord_q, ord_d;
  logic              cmp_lt;
  logic              cmp_eq;
  logic [ORD_W-1:0]  ord_max;
  logic              drain_busy;
  logic              drain_done;

  assign cmp_lt  = t_q < mem_rd_data_i.tstamp;
  assign cmp_eq  = t_q == mem_rd_data_i.tstamp;
  assign ord_max = (mem_rd_data_i.ord < ord_q) ? ord_q : mem_rd_data_i.ord;

  assign in_stall_o    = (state_q != S_IDLE);
  assign mem_rd_addr_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pos_q    <= pos_d;
    ins_q    <= ins_d;
    t_q      <= t_d;
    ord_q    <= ord_d;
  end

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    ins_d       = ins_q;
    t_d         = t_q;
    ord_d       = ord_q;
    mem_wr_o    = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d   = event_time_i;
          ord_d = event_order_i;
          if (action_i == ACT_DRAIN) begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESULT;
            end else begin
              pos_d   = '0;
              state_d = S_DRAIN_RD;
            end
          end else if (cnt_q == '0) begin
            mem_wr_o.en   = 1'b1;
            mem_wr_o.addr = '0;
            mem_wr_o.data = '{tstamp: event_time_i, ord: event_order_i};
            cnt_d         = CNT_W'(1);
            status_d      = ST_INSERTED;
            state_d       = S_RESULT;
          end else if (cnt_q == CNT_W'(LIST_SIZE - 1)) begin
            status_d = ST_DROPPED;
            state_d  = S_RESULT;
          end else begin
            pos_d   = cnt_q - CNT_W'(1);
            state_d = S_FIND_RD;
          end
        end
      end
      S_FIND_RD: begin
        state_d = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (cmp_eq) begin
          mem_wr_o.en   = 1'b1;
          mem_wr_o.addr = pos_q;
          mem_wr_o.data = '{tstamp: t_q, ord: ord_max};
          status_d      = ST_MERGED;
          state_d       = S_RESULT;
        end else if (cmp_lt) begin
          if (pos_q == '0) begin
            ins_d   = '0;
            pos_d   = cnt_q - CNT_W'(1);
            state_d = S_SHIFT_RD;
          end else begin
            pos_d   = pos_q - IDX_W'(1);
            state_d = S_FIND_RD;
          end
        end else begin
          ins_d = pos_q + IDX_W'(1);
          pos_d = cnt_q - CNT_W'(1);
          if (pos_q + IDX_W'(1) == cnt_q) begin
            state_d = S_WRITE;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end
      end
      S_SHIFT_RD: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        mem_wr_o.en   = 1'b1;
        mem_wr_o.addr = pos_q + IDX_W'(1);
        mem_wr_o.data = mem_rd_data_i;
        if (pos_q == ins_q) begin
          state_d = S_WRITE;
        end else begin
          pos_d   = pos_q - IDX_W'(1);
          state_d = S_SHIFT_RD;
        end
      end
      S_WRITE: begin
        mem_wr_o.en   = 1'b1;
        mem_wr_o.addr = ins_q;
        mem_wr_o.data = '{tstamp: t_q, ord: ord_q};
        cnt_d         = cnt_q + CNT_W'(1);
        status_d      = ST_INSERTED;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        res_valid_o = 1'b1;
        res_o.fill  = to_fill(cnt_q);
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_DRAIN_RD: begin
        state_d = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        res_valid_o  = 1'b1;
        res_o.status = ST_DRAINED;
        res_o.tstamp = mem_rd_data_i.tstamp;
        res_o.ord    = mem_rd_data_i.ord;
        res_o.fill   = to_fill(cnt_q - CNT_W'(1) - pos_q);
        res_o.last   = (pos_q == cnt_q - CNT_W'(1));
        if (res_ready_i) begin
          if (res_o.last) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            pos_d   = pos_q + IDX_W'(1);
            state_d = S_DRAIN_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign drain_busy = (state_q == S_DRAIN_RD) || (state_q == S_DRAIN_OUT);
  assign drain_done = (state_q == S_DRAIN_OUT) && res_ready_i && res_o.last;

  `ASSERT_PROP(a_drain_in_range, clk_i, rst_ni, drain_busy |-> (pos_q < cnt_q))
  `ASSERT_PROP(a_drain_clears, clk_i, rst_ni, drain_done |=> (cnt_q == '0))
  `ASSERT_NEVER(a_shift_order, clk_i, rst_ni, (state_q == S_SHIFT_RD && pos_q < ins_q))

endmodule

// ===== rtl/core/sorted_time_list_order_merge.sv =====
// Top level of the sorted time list with order merge and its output register.
//
//   channel  direction  handshake               fields
//   in       input      in_valid_i / in_stall_o  action, event_time, event_order
//   out      output     out_valid_o / out_stall_i status, entry_time, entry_order,
//                                                fill_count, last
//
// An insert into an empty or full list, or a drain of an empty one, goes straight to the result.
// Any other insert reads and compares entries from the top down, then moves each later entry up
// one place, all through the single read port of the entry memory, and writes the new entry
// unless it merges. A drain reads out the held entries in ascending time order.
// Reset clears the entry count, the sequencer state and the output valid flag, so no clearing pass is needed.
// A stalled result holds the sequencer, and no new request is taken until the last
// result of the current one has entered the output register.
`timescale 1ns / 1ps
module sorted_time_list_order_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [stlom_pkg::TIME_W-1:0]  event_time_i,
  input  logic [stlom_pkg::ORD_W-1:0]   event_order_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [stlom_pkg::TIME_W-1:0]  entry_time_o,
  output logic [stlom_pkg::ORD_W-1:0]   entry_order_o,
  output logic [stlom_pkg::FILL_W-1:0]  fill_count_o,
  output logic                          last_o
);
  import stlom_pkg::*;

  mem_wr_t          mem_wr;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  res_t             out_q;
  logic             out_valid_q;

  stlom_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  stlom_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .event_time_i  (event_time_i),
    .event_order_i (event_order_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_wr_o      (mem_wr),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign entry_time_o  = out_q.tstamp;
  assign entry_order_o = out_q.ord;
  assign fill_count_o  = out_q.fill;
  assign last_o        = out_q.last;

endmodule
